### rtl/tfd_pkg.sv
// Package: beat types, register map and code constants for the tilt/fall detector.
`timescale 1ns / 1ps

package tfd_pkg;

    localparam int ANGLE_W = 16;
    localparam int TIME_W  = 32;
    localparam int Q14_W   = 16;
    localparam int LIMIT_W = 15;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_FALL_ENTER   = 3'd0;
    localparam logic [2:0] REG_UPRIGHT_EXIT = 3'd1;
    localparam logic [2:0] REG_DIR_THR      = 3'd2;
    localparam logic [2:0] REG_FALL_TIME    = 3'd3;
    localparam logic [2:0] REG_UP_TIME      = 3'd4;
    localparam logic [2:0] REG_ARC_START    = 3'd5;
    localparam logic [2:0] REG_ARC_END      = 3'd6;

    // Direction codes
    localparam logic [2:0] DIR_UNKNOWN = 3'd0;
    localparam logic [2:0] DIR_FRONT   = 3'd1;
    localparam logic [2:0] DIR_BACK    = 3'd2;
    localparam logic [2:0] DIR_LEFT    = 3'd3;
    localparam logic [2:0] DIR_RIGHT   = 3'd4;

    // Cause codes
    localparam logic [1:0] REASON_NONE    = 2'd0;
    localparam logic [1:0] REASON_INVALID = 2'd1;
    localparam logic [1:0] REASON_LEG     = 2'd2;
    localparam logic [1:0] REASON_TILT    = 2'd3;

    // Register reset values
    localparam logic [LIMIT_W-1:0]        FALL_ENTER_RST   = 15'd8192;
    localparam logic [LIMIT_W-1:0]        UPRIGHT_EXIT_RST = 15'd4915;
    localparam logic [LIMIT_W-1:0]        DIR_THR_RST      = 15'd3277;
    localparam logic [TIME_W-1:0]         FALL_TIME_RST    = 32'd200;
    localparam logic [TIME_W-1:0]         UP_TIME_RST      = 32'd500;
    localparam logic signed [ANGLE_W-1:0] ARC_START_RST    = -16'sd10923;
    localparam logic signed [ANGLE_W-1:0] ARC_END_RST      = 16'sd10923;

    typedef struct packed {
        logic                       sample_valid;
        logic signed [Q14_W-1:0]    up_x;
        logic signed [Q14_W-1:0]    up_y;
        logic signed [ANGLE_W-1:0]  left_leg_angle;
        logic signed [ANGLE_W-1:0]  right_leg_angle;
        logic        [TIME_W-1:0]   now_ms;
    } in_beat_t;

    typedef struct packed {
        logic               valid_echo;
        logic [2:0]         fall_dir;
        logic [1:0]         fall_reason;
        logic               legs_safe;
        logic               leg_candidate;
        logic [TIME_W-1:0]  fall_hold_ms;
        logic               fall_qualified;
        logic [TIME_W-1:0]  upright_held_ms;
        logic               tilt_within_exit;
        logic               upright_confirmed;
        logic               any_candidate;
    } out_beat_t;

endpackage

### rtl/tilt_fall_detector_top.sv
// Top level: tilt/fall detector with APB register file and two-stage pipeline.
`timescale 1ns / 1ps
//
// Usage
//   Input channel (in_valid/in_stall/in_data) carries one sensor sample per beat.
//   Output channel (out_valid/out_stall/out_data) carries one status beat per
//   sample, in order. Every input beat yields exactly one output beat.
//   Path: an accepted input beat passes the input register, then the result
//   register, before out_valid rises with its status beat. Throughput: one
//   beat per cycle while out_stall is low; the logic between the two
//   registers is a single compare/subtract pass.
//   Stall: when out_stall holds the result register, the input register still
//   takes one more beat if empty, then in_stall rises until the result drains.
//   Reset (rst_n low, async): pipeline empty, hold timers and latched
//   direction/cause cleared, registers back to their default limits/times.
//   Registers are written through APB (4-byte stride, pready tied high) and
//   should only change while the pipeline is empty.
//   Invalid samples report the latched direction with the sensor-invalid
//   cause and leave the timers and latch untouched.

module tilt_fall_detector_top
    import tfd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // sample channel
    input  logic                in_valid,
    output logic                in_stall,
    input  in_beat_t            in_data,
    // status channel
    output logic                out_valid,
    input  logic                out_stall,
    output out_beat_t           out_data,
    // APB register port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    // ---------------- register file ----------------
    logic [LIMIT_W-1:0]        fall_enter_reg;
    logic [LIMIT_W-1:0]        upright_exit_reg;
    logic [LIMIT_W-1:0]        dir_thr_reg;
    logic [TIME_W-1:0]         fall_time_reg;
    logic [TIME_W-1:0]         up_time_reg;
    logic signed [ANGLE_W-1:0] arc_start_reg;
    logic signed [ANGLE_W-1:0] arc_end_reg;
    logic                      wr_en;
    logic [2:0]                reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fall_enter_reg   <= FALL_ENTER_RST;
            upright_exit_reg <= UPRIGHT_EXIT_RST;
            dir_thr_reg      <= DIR_THR_RST;
            fall_time_reg    <= FALL_TIME_RST;
            up_time_reg      <= UP_TIME_RST;
            arc_start_reg    <= ARC_START_RST;
            arc_end_reg      <= ARC_END_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_FALL_ENTER:   fall_enter_reg   <= pwdata[LIMIT_W-1:0];
                REG_UPRIGHT_EXIT: upright_exit_reg <= pwdata[LIMIT_W-1:0];
                REG_DIR_THR:      dir_thr_reg      <= pwdata[LIMIT_W-1:0];
                REG_FALL_TIME:    fall_time_reg    <= pwdata[TIME_W-1:0];
                REG_UP_TIME:      up_time_reg      <= pwdata[TIME_W-1:0];
                REG_ARC_START:    arc_start_reg    <= pwdata[ANGLE_W-1:0];
                REG_ARC_END:      arc_end_reg      <= pwdata[ANGLE_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_FALL_ENTER:   prdata = {{(DATA_W-LIMIT_W){1'b0}}, fall_enter_reg};
            REG_UPRIGHT_EXIT: prdata = {{(DATA_W-LIMIT_W){1'b0}}, upright_exit_reg};
            REG_DIR_THR:      prdata = {{(DATA_W-LIMIT_W){1'b0}}, dir_thr_reg};
            REG_FALL_TIME:    prdata = fall_time_reg;
            REG_UP_TIME:      prdata = up_time_reg;
            REG_ARC_START:    prdata = {{(DATA_W-ANGLE_W){1'b0}}, arc_start_reg};
            REG_ARC_END:      prdata = {{(DATA_W-ANGLE_W){1'b0}}, arc_end_reg};
            default:          prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    logic      s1_valid_reg;
    in_beat_t  s1_data_reg;
    logic      out_valid_reg;
    out_beat_t out_data_reg;
    logic      advance;      // result register can take a beat
    logic      s1_load;
    logic      s1_fire;      // stage-1 beat moves to result register

    assign advance   = !(out_valid_reg && out_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign s1_load   = in_valid && !in_stall;
    assign s1_fire   = s1_valid_reg && advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_load)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_data_reg <= in_data;
        end
    end

    // ---------------- detector state ----------------
    logic              was_fall_reg,    was_fall_next;
    logic [TIME_W-1:0] fall_start_reg,  fall_start_next;
    logic              was_up_reg,      was_up_next;
    logic [TIME_W-1:0] up_start_reg,    up_start_next;
    logic [2:0]        latched_dir_reg, latched_dir_next;
    logic [1:0]        latched_rsn_reg, latched_rsn_next;
    logic              latch_held_reg,  latch_held_next;
    out_beat_t         result;

    // tilt magnitudes (17 bits covers |-32768|)
    logic [Q14_W:0]          ax, ay;
    logic signed [Q14_W+1:0] ux_e, uy_e, thr_e;
    logic                    raw_up, tilt_cand, left_ok, right_ok, legs_ok;
    logic                    leg_cand, cand, confirmed, up_cand;
    logic signed [ANGLE_W:0] span;
    logic [ANGLE_W-1:0]      left_off, right_off;
    logic [TIME_W-1:0]       fall_base, up_base, fall_hold, up_hold;
    logic [2:0]              dir_pick;

    always_comb
    begin
        ux_e  = {{2{s1_data_reg.up_x[Q14_W-1]}}, s1_data_reg.up_x};
        uy_e  = {{2{s1_data_reg.up_y[Q14_W-1]}}, s1_data_reg.up_y};
        thr_e = {3'b000, dir_thr_reg};
        ax    = ux_e[Q14_W+1] ? (Q14_W+1)'(0) - ux_e[Q14_W:0] : ux_e[Q14_W:0];
        ay    = uy_e[Q14_W+1] ? (Q14_W+1)'(0) - uy_e[Q14_W:0] : uy_e[Q14_W:0];

        raw_up    = (ax <= {2'b00, upright_exit_reg}) && (ay <= {2'b00, upright_exit_reg});
        tilt_cand = (ax > {2'b00, fall_enter_reg}) || (ay > {2'b00, fall_enter_reg});

        // wrapped arc: offset from start must not exceed the signed span
        span      = {arc_end_reg[ANGLE_W-1], arc_end_reg}
                  - {arc_start_reg[ANGLE_W-1], arc_start_reg};
        left_off  = s1_data_reg.left_leg_angle - arc_start_reg;
        right_off = s1_data_reg.right_leg_angle - arc_start_reg;
        left_ok   = !span[ANGLE_W] && ({1'b0, left_off} <= span[ANGLE_W:0]);
        right_ok  = !span[ANGLE_W] && ({1'b0, right_off} <= span[ANGLE_W:0]);
        legs_ok   = left_ok && right_ok;
        leg_cand  = !legs_ok;
        cand      = tilt_cand || leg_cand;

        fall_base = was_fall_reg ? fall_start_reg : s1_data_reg.now_ms;
        fall_hold = cand ? s1_data_reg.now_ms - fall_base : '0;
        confirmed = cand && (fall_hold >= fall_time_reg);

        up_cand = raw_up && legs_ok;
        up_base = was_up_reg ? up_start_reg : s1_data_reg.now_ms;
        up_hold = up_cand ? s1_data_reg.now_ms - up_base : '0;

        // direction: threshold tests in order, else larger magnitude (x wins ties)
        if (ux_e < -thr_e)
            dir_pick = DIR_FRONT;
        else if (ux_e > thr_e)
            dir_pick = DIR_BACK;
        else if (uy_e < -thr_e)
            dir_pick = DIR_LEFT;
        else if (uy_e > thr_e)
            dir_pick = DIR_RIGHT;
        else if (ax >= ay)
            dir_pick = ux_e[Q14_W+1] ? DIR_FRONT : DIR_BACK;
        else
            dir_pick = uy_e[Q14_W+1] ? DIR_LEFT : DIR_RIGHT;

        // defaults: state holds
        was_fall_next    = was_fall_reg;
        fall_start_next  = fall_start_reg;
        was_up_next      = was_up_reg;
        up_start_next    = up_start_reg;
        latched_dir_next = latched_dir_reg;
        latched_rsn_next = latched_rsn_reg;
        latch_held_next  = latch_held_reg;
        result           = '0;

        if (!s1_data_reg.sample_valid)
        begin
            result.fall_dir    = latched_dir_reg;
            result.fall_reason = REASON_INVALID;
        end
        else
        begin
            if (confirmed && !latch_held_reg)
            begin
                // first confirmed beat: capture direction and cause
                latched_dir_next = (!tilt_cand) ? DIR_UNKNOWN : dir_pick;
                latched_rsn_next = leg_cand ? REASON_LEG : REASON_TILT;
                latch_held_next  = 1'b1;
            end
            else if (!confirmed)
            begin
                latched_dir_next = DIR_UNKNOWN;
                latched_rsn_next = REASON_NONE;
                latch_held_next  = 1'b0;
            end

            if (cand && !was_fall_reg)
                fall_start_next = s1_data_reg.now_ms;
            if (up_cand && !was_up_reg)
                up_start_next = s1_data_reg.now_ms;
            was_fall_next = cand;
            was_up_next   = up_cand;

            result.valid_echo        = 1'b1;
            result.fall_dir          = latched_dir_next;
            result.fall_reason       = latched_rsn_next;
            result.legs_safe         = legs_ok;
            result.leg_candidate     = leg_cand;
            result.fall_hold_ms      = fall_hold;
            result.fall_qualified    = confirmed;
            result.upright_held_ms   = up_hold;
            result.tilt_within_exit  = raw_up;
            result.upright_confirmed = (up_hold >= up_time_reg);
            result.any_candidate     = cand;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            was_fall_reg    <= 1'b0;
            fall_start_reg  <= '0;
            was_up_reg      <= 1'b0;
            up_start_reg    <= '0;
            latched_dir_reg <= DIR_UNKNOWN;
            latched_rsn_reg <= REASON_NONE;
            latch_held_reg  <= 1'b0;
        end
        else if (s1_fire)
        begin
            was_fall_reg    <= was_fall_next;
            fall_start_reg  <= fall_start_next;
            was_up_reg      <= was_up_next;
            up_start_reg    <= up_start_next;
            latched_dir_reg <= latched_dir_next;
            latched_rsn_reg <= latched_rsn_next;
            latch_held_reg  <= latch_held_next;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_data_reg <= result;
        end
    end

endmodule
